>>> hdl/windowed_moving_average_macros.svh
// Assertion macros for the windowed moving average block.
// Included by the top level; define ASSERT_OFF to drop all checks.
`ifndef WINDOWED_MOVING_AVERAGE_MACROS_SVH
`define WINDOWED_MOVING_AVERAGE_MACROS_SVH

`ifndef ASSERT_OFF

// Antecedent holds, consequent holds in the same cycle.
`define WMA_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("windowed_moving_average: check failed");

// Antecedent holds, consequent holds in the next cycle.
`define WMA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("windowed_moving_average: check failed");

`else

`define WMA_ASSERT_NOW(label, clk, rstn, ante, cons)
`define WMA_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

>>> hdl/wma_pkg.sv
// Shared constants and types for the windowed moving average block.
// No dependencies.
`default_nettype none

package wma_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int COND_W    = 14;
  localparam int MEAN_W    = 18;
  localparam int FRAC_W    = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_UPD   = 5'b00010,
    ST_START = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

endpackage

`default_nettype wire

>>> hdl/wma_div.sv
// Iterative restoring divider, one quotient bit per cycle, signed dividend
// truncated toward zero by a nonzero unsigned divisor. No dependencies.
`default_nettype none

module wma_div #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] dividend_i,
  input  logic        [DEN_W-1:0] divisor_i,
  output logic                    done_o,
  output logic signed [NUM_W-1:0] quotient_o
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic              neg_q;
  logic [NUM_W-1:0]  quo_q;
  logic [DEN_W-1:0]  rem_q;

  logic [DEN_W:0]    rem_sh;
  logic [DEN_W+1:0]  diff;
  logic              fit;
  logic [NUM_W-1:0]  mag;

  assign rem_sh = {rem_q, quo_q[NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, divisor_i};
  assign fit    = ~diff[DEN_W+1];
  assign mag    = dividend_i[NUM_W-1] ? NUM_W'(-dividend_i) : NUM_W'(dividend_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(NUM_W);
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[NUM_W-1];
      quo_q <= mag;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], fit};
      rem_q <= fit ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

`default_nettype wire

>>> hdl/windowed_moving_average.sv
// Windowed moving average top level: sample conditioning, ring store,
// running total and output register. Uses wma_pkg and wma_div.
`default_nettype none
`include "windowed_moving_average_macros.svh"

// Each sample item is optionally doubled, reduced by offset_mv and written
// over the oldest of WINDOW ring entries; the result item is the mean of the
// filled entries times 16, truncated toward zero. From acceptance, one item
// updates the total, starts the divider, runs the divider at one quotient
// bit per cycle, waits for the divider's done flag and then loads the
// result; the ring is read in the accepting cycle. The next item can be
// taken in the cycle after the result is loaded; a stalled result still in
// the output register delays that load. in_stall_o stays high meanwhile. A
// result may wait in the output register while the next item is accepted.
// No clearing pass after reset: entries not yet written read as zero via
// the fill count. Configuration writes are always taken.
module windowed_moving_average
  import wma_pkg::*;
#(
  parameter int WINDOW = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic        [CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [SAMPLE_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic        [SAMPLE_W-1:0]  sample_mv_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [MEAN_W-1:0]    mean_q4_o
);

  localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int TOTAL_W = COND_W + $clog2(WINDOW);
  localparam int NUM_W   = TOTAL_W + FRAC_W;

  state_e state_q, state_d;

  logic                      double_q;
  logic [SAMPLE_W-1:0]       offset_q;
  logic [SLOT_W-1:0]         slot_q;
  logic [CNT_W-1:0]          count_q;
  logic signed [TOTAL_W-1:0] total_q;
  logic signed [COND_W-1:0]  cond_q;
  logic signed [COND_W-1:0]  old_q;
  logic signed [COND_W-1:0]  ring_q [WINDOW];
  logic                      out_valid_q;
  logic signed [MEAN_W-1:0]  mean_q;

  logic                      in_take;
  logic                      full;
  logic [SAMPLE_W:0]         scaled;
  logic signed [COND_W-1:0]  cond;
  logic signed [COND_W-1:0]  old_val;
  logic                      out_free;
  logic                      div_start;
  logic                      div_done;
  logic signed [NUM_W-1:0]   quotient;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_take     = in_valid_i && !in_stall_o;
  assign full        = (count_q == CNT_W'(WINDOW));
  assign scaled      = double_q ? {sample_mv_i, 1'b0} : {1'b0, sample_mv_i};
  assign cond        = $signed({1'b0, scaled}) - $signed({2'b00, offset_q});
  assign old_val     = full ? old_q : '0;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign div_start   = (state_q == ST_START);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_take) state_d = ST_UPD;
      ST_UPD:   state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV:   if (div_done) state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      double_q    <= 1'b1;
      offset_q    <= '0;
      slot_q      <= '0;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_DOUBLE: double_q <= cfg_data_i[0];
          CFG_OFFSET: offset_q <= cfg_data_i;
          default:    ;
        endcase
      end
      if (state_q == ST_UPD) begin
        total_q <= total_q - TOTAL_W'(old_val) + TOTAL_W'(cond_q);
        slot_q  <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
        if (!full) begin
          count_q <= count_q + CNT_W'(1);
        end
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cond_q <= cond;
    end
    if (state_q == ST_OUT && out_free) begin
      mean_q <= quotient[MEAN_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPD) begin
      ring_q[slot_q] <= cond_q;
    end
    old_q <= ring_q[slot_q];
  end

  wma_div #(
    .NUM_W(NUM_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({total_q, {FRAC_W{1'b0}}}),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign out_valid_o = out_valid_q;
  assign mean_q4_o   = mean_q;

  `WMA_ASSERT_NOW(a_slot_tracks_fill, clk_i, rst_ni, !full, CNT_W'(slot_q) == count_q)
  `WMA_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(WINDOW))
  `WMA_ASSERT_NOW(a_done_in_div, clk_i, rst_ni, div_done, state_q == ST_DIV)
  `WMA_ASSERT_NEXT(a_upd_fills, clk_i, rst_ni, state_q == ST_UPD, count_q != '0)

endmodule

`default_nettype wire
